### design/hbfd_pkg.sv
package hbfd_pkg;

    // Default configuration
    localparam int TAPS_DEF         = 51;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 18;

    // Fixed width of the coefficient slot field
    localparam int CIDX_W = 4;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_EMIT = 2'd0,
        KIND_PUSH = 2'd1,
        KIND_LOAD = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

endpackage

### design/hbfd_tap_cell.sv
module hbfd_tap_cell #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  logic signed [W-1:0] din,
    output logic signed [W-1:0] q
);

    logic signed [W-1:0] q_reg;

    // Take din on every push: the neighbor's sample, or the new sample at the top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (shift)
        begin
            q_reg <= din;
        end
    end

    assign q = q_reg;

endmodule

### design/hbfd_pair_cell.sv
module hbfd_pair_cell #(
    parameter int W = 17
) (
    input  logic                clk,
    input  logic                load,
    input  logic                shift,
    input  logic signed [W-1:0] load_val,
    input  logic signed [W-1:0] nbr,
    output logic signed [W-1:0] q
);

    logic signed [W-1:0] q_reg;

    // Capture the folded pair, then pass it toward the multiplier
    always_ff @(posedge clk)
    begin
        priority if (load)
        begin
            q_reg <= load_val;
        end
        else if (shift)
        begin
            q_reg <= nbr;
        end
    end

    assign q = q_reg;

endmodule

### design/hbfd_mac.sv
module hbfd_mac #(
    parameter int SW = 16,
    parameter int CW = 18,
    parameter int PW = 17,
    parameter int AW = 40
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbfd_pkg::mac_ctrl_t  ctrl,
    input  logic signed [PW-1:0] head,
    input  logic signed [CW-1:0] coef,
    output logic signed [SW-1:0] filtered
);
    import hbfd_pkg::*;

    localparam int PRW = PW + CW;
    localparam logic signed [AW-1:0] HALF   = AW'(1) << (CW - 2);
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    logic signed [PRW-1:0] prod_reg;
    logic signed [PRW-1:0] prod_next;
    logic                  prod_vld_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [AW-1:0]  biased;
    logic signed [AW-1:0]  shifted;

    // Multiply the head pair by its coefficient
    assign prod_next = head * coef;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

    // Accumulate at full precision
    always_ff @(posedge clk)
    begin
        priority if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    // Round to nearest, ties upward, then clamp to the sample range
    always_comb
    begin
        biased  = acc_reg + HALF;
        shifted = biased >>> (CW - 1);
        priority if (shifted > SAT_HI)
        begin
            filtered = SAT_HI[SW-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            filtered = SAT_LO[SW-1:0];
        end
        else
        begin
            filtered = shifted[SW-1:0];
        end
    end

endmodule

### design/halfband_fir_decimator_unit.sv
// Half-band FIR decimator. Each s_tuser kind selects one transaction type:
// push-and-emit, push-only (use every other one for decimation by two), or
// a coefficient load into slot coef_index (the last slot is the center tap;
// slots past the table are dropped, kind 3 is dropped). Push-only, load and
// dropped items are handled in ST_IDLE alone. A push-and-emit item is
// accepted in ST_IDLE, folds the mirror pairs into the pair cells in ST_LOAD,
// walks the pair chain past the single shared multiplier through every unique
// coefficient in ST_RUN, drains the product register in ST_DRAIN, and rounds
// and writes the output register in ST_DONE. A waiting result does not block
// the next input, but a later push-and-emit holds in ST_DONE until the
// waiting result is taken. Coefficients and delay line reset to zero.
module halfband_fir_decimator_unit #(
    parameter int TAPS         = hbfd_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = hbfd_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = hbfd_pkg::COEF_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata: sample, coef_index, coef_value, zero fill
    input  logic [((SAMPLE_WIDTH+hbfd_pkg::CIDX_W+COEF_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser: kind
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata: filtered, zero fill
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);
    import hbfd_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COEF_WIDTH;
    localparam int PW     = SW + 1;
    localparam int CENTER = (TAPS - 1) / 2;
    localparam int NUNIQ  = (CENTER + 1) / 2 + 1;
    localparam int KW     = $clog2(NUNIQ);
    localparam int AW     = PW + CW + KW + 1;
    localparam int OW     = ((SW + 7) / 8) * 8;
    localparam int IDX_LO = SW;
    localparam int VAL_LO = SW + CIDX_W;

    state_t    state_reg, state_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    mac_ctrl_t mac_ctrl;
    logic      pair_load;
    logic      pair_shift;
    logic      out_load;

    logic                 accept;
    kind_t                kind;
    logic signed [SW-1:0] in_sample;
    logic [CIDX_W-1:0]    in_idx;
    logic signed [CW-1:0] in_coef;
    logic                 push;
    logic                 coef_we;
    logic [KW-1:0]        coef_waddr;

    logic signed [SW-1:0] tap_q    [TAPS];
    logic signed [PW-1:0] pair_val [NUNIQ];
    logic signed [PW-1:0] pair_q   [NUNIQ];
    logic signed [CW-1:0] coef_tab_reg [NUNIQ];
    logic signed [CW-1:0] coef_rd;
    logic signed [SW-1:0] filtered;

    logic          out_valid_reg;
    logic [SW-1:0] out_data_reg;

    // Decode the input transaction
    assign accept    = s_tvalid && s_tready;
    assign kind      = kind_t'(s_tuser);
    assign in_sample = s_tdata[SW-1:0];
    assign in_idx    = s_tdata[IDX_LO +: CIDX_W];
    assign in_coef   = s_tdata[VAL_LO +: CW];
    assign coef_waddr = KW'(in_idx);

    always_comb
    begin
        push    = 1'b0;
        coef_we = 1'b0;
        unique case (kind)
            KIND_EMIT: push = accept;
            KIND_PUSH: push = accept;
            KIND_LOAD: coef_we = accept && (32'(in_idx) < NUNIQ);
            KIND_NONE: push = 1'b0;
        endcase
    end

    // Delay line: newest sample enters at the top, index 0 is the oldest
    genvar gi;
    generate
        for (gi = 0; gi < TAPS; gi++)
        begin : g_tap
            logic signed [SW-1:0] din;
            if (gi == TAPS - 1)
            begin : g_top
                assign din = in_sample;
            end
            else
            begin : g_mid
                assign din = tap_q[gi+1];
            end
            hbfd_tap_cell #(.W(SW)) u_tap (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (push),
                .din   (din),
                .q     (tap_q[gi])
            );
        end
    endgenerate

    // Pair cells: folded mirror sums, center tap in the last cell
    generate
        for (gi = 0; gi < NUNIQ; gi++)
        begin : g_pair
            logic signed [PW-1:0] nbr;
            if (gi == NUNIQ - 1)
            begin : g_ctr
                assign pair_val[gi] = PW'(tap_q[CENTER]);
                assign nbr          = '0;
            end
            else
            begin : g_fold
                assign pair_val[gi] = PW'(tap_q[2*gi]) + PW'(tap_q[TAPS-1-2*gi]);
                assign nbr          = pair_q[gi+1];
            end
            hbfd_pair_cell #(.W(PW)) u_pair (
                .clk      (clk),
                .load     (pair_load),
                .shift    (pair_shift),
                .load_val (pair_val[gi]),
                .nbr      (nbr),
                .q        (pair_q[gi])
            );
        end
    endgenerate

    // Coefficient table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUNIQ; i++)
            begin
                coef_tab_reg[i] <= '0;
            end
        end
        else if (coef_we)
        begin
            coef_tab_reg[coef_waddr] <= in_coef;
        end
    end

    assign coef_rd = coef_tab_reg[cnt_reg];

    hbfd_mac #(
        .SW (SW),
        .CW (CW),
        .PW (PW),
        .AW (AW)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .head     (pair_q[0]),
        .coef     (coef_rd),
        .filtered (filtered)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and controls
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mac_ctrl       = '0;
        pair_load      = 1'b0;
        pair_shift     = 1'b0;
        out_load       = 1'b0;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept && kind == KIND_EMIT)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                pair_load      = 1'b1;
                mac_ctrl.clear = 1'b1;
                cnt_next       = '0;
                state_next     = ST_RUN;
            end
            ST_RUN:
            begin
                mac_ctrl.mul_en = 1'b1;
                pair_shift      = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == KW'(NUNIQ - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= filtered;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OW'(out_data_reg);

    // Push-and-emit starts the fold on the next cycle
    a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_EMIT) |=> state_reg == ST_LOAD)
        else $error("emit transaction did not start the filter pass");

    // Coefficient counter stays inside the table during the pass
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> 32'(cnt_reg) < NUNIQ)
        else $error("coefficient counter out of range");

    // A new result appears only at the end of a filter pass
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared outside a filter pass");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");

endmodule
